[hdl/etc_pkg.sv]
// Shared types and constants for the expression tokenizer and checker.
// Token kinds, check status codes and the word formats passed between the front,
// token queue and back. Depends on nothing.
package etc_pkg;

  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_PLUS   = 4'd2,
    KIND_MINUS  = 4'd3,
    KIND_STAR   = 4'd4,
    KIND_SLASH  = 4'd5,
    KIND_CARET  = 4'd6,
    KIND_OPEN   = 4'd7,
    KIND_CLOSE  = 4'd8,
    KIND_ERROR  = 4'd9,
    KIND_END    = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_SYNTAX = 2'd2,
    STATUS_PAREN  = 2'd3
  } status_t;

  // One token as the scanner found it, before checking.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // Up to two tokens written into the token queue in one cycle, oldest first.
  typedef struct packed {
    logic v0;
    tok_t t0;
    logic v1;
    tok_t t1;
  } tq_wr_t;

  // Head of the token queue as the back sees it.
  typedef struct packed {
    logic valid;
    tok_t tok;
  } tq_head_t;

  // One finished result word.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    status_t     status;
    logic        last;
  } res_t;

  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);
  localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

endpackage

[hdl/etc_front.sv]
// Scanner front: classifies each character, tracks the token in progress and
// the text position, and writes up to two tokens per word into the token queue.
// Depends on etc_pkg.
module etc_front #(
  parameter longint unsigned MAX_TEXT_LENGTH = 65535
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      in_ch,
  input  logic            in_end_of_text,
  input  logic            room,
  output logic            full,
  output etc_pkg::tq_wr_t wr
);

  localparam int POS_W = $clog2(MAX_TEXT_LENGTH + 1);

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_INT   = 4'b0010,
    MODE_FRAC  = 4'b0100,
    MODE_IDENT = 4'b1000
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pend_r, pend_nxt;
  logic [POS_W-1:0] pend_len;
  logic [POS_W-1:0] pos_adv;

  logic acc, is_digit, is_letter, is_space, is_dot;
  logic cont, flush, sym;
  etc_pkg::kind_t sym_kind;

  function automatic logic [15:0] lo16(input logic [POS_W-1:0] v);
    logic [POS_W+15:0] w;
    w = {16'd0, v};
    return w[15:0];
  endfunction

  assign acc       = push && room;
  assign full      = !room;
  assign is_digit  = (in_ch >= 8'h30) && (in_ch <= 8'h39);
  assign is_letter = ((in_ch >= 8'h41) && (in_ch <= 8'h5A)) ||
                     ((in_ch >= 8'h61) && (in_ch <= 8'h7A));
  assign is_space  = (in_ch == 8'h20) || ((in_ch >= 8'h09) && (in_ch <= 8'h0D));
  assign is_dot    = (in_ch == etc_pkg::CH_DOT);

  // A character that extends the token in progress produces nothing.
  assign cont  = !in_end_of_text &&
                 (((mode_r == MODE_INT) && (is_digit || is_dot)) ||
                  ((mode_r == MODE_FRAC) && is_digit) ||
                  ((mode_r == MODE_IDENT) && is_letter));
  assign flush = !cont && (mode_r != MODE_IDLE);
  assign sym   = !in_end_of_text && !cont && !is_space && !is_digit && !is_letter;

  assign pend_len = pos_r - pend_r;
  assign pos_adv  = (pos_r < POS_W'(MAX_TEXT_LENGTH)) ? pos_r + POS_W'(1) : pos_r;

  always_comb begin
    case (in_ch)
      etc_pkg::CH_PLUS:  sym_kind = etc_pkg::KIND_PLUS;
      etc_pkg::CH_MINUS: sym_kind = etc_pkg::KIND_MINUS;
      etc_pkg::CH_STAR:  sym_kind = etc_pkg::KIND_STAR;
      etc_pkg::CH_SLASH: sym_kind = etc_pkg::KIND_SLASH;
      etc_pkg::CH_CARET: sym_kind = etc_pkg::KIND_CARET;
      etc_pkg::CH_OPEN:  sym_kind = etc_pkg::KIND_OPEN;
      etc_pkg::CH_CLOSE: sym_kind = etc_pkg::KIND_CLOSE;
      default:           sym_kind = etc_pkg::KIND_ERROR;
    endcase
  end

  always_comb begin
    wr.v0        = acc && flush;
    wr.t0.kind   = (mode_r == MODE_IDENT) ? etc_pkg::KIND_IDENT : etc_pkg::KIND_NUMBER;
    wr.t0.start  = lo16(pend_r);
    wr.t0.length = lo16(pend_len);
    wr.t0.last   = !(in_end_of_text || sym);
    wr.v1        = acc && (in_end_of_text || sym);
    wr.t1.kind   = in_end_of_text ? etc_pkg::KIND_END : sym_kind;
    wr.t1.start  = lo16(pos_r);
    wr.t1.length = in_end_of_text ? 16'd0 : 16'd1;
    wr.t1.last   = 1'b1;
  end

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    if (acc) begin
      if (in_end_of_text) begin
        mode_nxt = MODE_IDLE;
        pos_nxt  = '0;
        pend_nxt = '0;
      end else begin
        pos_nxt = pos_adv;
        if (cont) begin
          if ((mode_r == MODE_INT) && is_dot) begin
            mode_nxt = MODE_FRAC;
          end
        end else if (is_digit) begin
          mode_nxt = MODE_INT;
          pend_nxt = pos_r;
        end else if (is_letter) begin
          mode_nxt = MODE_IDENT;
          pend_nxt = pos_r;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      pend_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

[hdl/etc_tok_queue.sv]
// Short token queue between scanner front and checker back: takes up to two
// tokens per cycle; gives one per cycle while rd is high. Depends on etc_pkg.
module etc_tok_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  etc_pkg::tq_wr_t   wr,
  input  logic              rd,
  output logic              room,
  output etc_pkg::tq_head_t head
);

  etc_pkg::tok_t                 mem_r [etc_pkg::TQ_DEPTH];
  logic [etc_pkg::TQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [etc_pkg::TQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [etc_pkg::TQ_CW-1:0]     cnt_r, cnt_nxt;
  logic [etc_pkg::TQ_AW-1:0]     wr_ptr1;
  logic                          do_rd;

  assign room       = (cnt_r <= etc_pkg::TQ_CW'(etc_pkg::TQ_DEPTH - 2));
  assign head.valid = (cnt_r != '0);
  assign head.tok   = mem_r[rd_ptr_r];
  assign do_rd      = rd && head.valid;
  assign wr_ptr1    = wr.v0 ? wr_ptr_r + etc_pkg::TQ_AW'(1) : wr_ptr_r;

  always_comb begin
    rd_ptr_nxt = do_rd ? rd_ptr_r + etc_pkg::TQ_AW'(1) : rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r + etc_pkg::TQ_AW'(wr.v0) + etc_pkg::TQ_AW'(wr.v1);
    cnt_nxt    = cnt_r + etc_pkg::TQ_CW'(wr.v0) + etc_pkg::TQ_CW'(wr.v1)
                 - etc_pkg::TQ_CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (wr.v0) begin
      mem_r[wr_ptr_r] <= wr.t0;
    end
    if (wr.v1) begin
      mem_r[wr_ptr1] <= wr.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hdl/etc_back.sv]
// Checker back: applies the successor and parenthesis rules to each token,
// computes the status of the end token and holds results in a two-word queue.
// Depends on etc_pkg.
module etc_back #(
  parameter int unsigned MAX_PAREN_DEPTH = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  etc_pkg::tq_head_t head,
  output logic              rd,
  input  logic              pop,
  output logic              empty,
  output etc_pkg::res_t     res
);

  localparam int DEPTH_W = $clog2(MAX_PAREN_DEPTH + 1);

  etc_pkg::kind_t   prev_r, prev_nxt;
  logic             have_r, have_nxt;
  logic             first_r, first_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  etc_pkg::status_t err_r, err_nxt;

  etc_pkg::res_t    oq_r [2];
  logic             oq_head_r, oq_head_nxt;
  logic [1:0]       oq_cnt_r, oq_cnt_nxt;
  logic             do_pop;

  etc_pkg::kind_t   kind;
  etc_pkg::status_t code, end_status;
  etc_pkg::res_t    res_new;
  logic             prev_needs, seq_err, op_start;

  assign kind       = head.tok.kind;
  assign rd         = head.valid && (oq_cnt_r != 2'd2);
  assign prev_needs = (prev_r >= etc_pkg::KIND_PLUS) && (prev_r <= etc_pkg::KIND_OPEN);
  assign op_start   = (kind == etc_pkg::KIND_NUMBER) || (kind == etc_pkg::KIND_IDENT) ||
                      (kind == etc_pkg::KIND_PLUS) || (kind == etc_pkg::KIND_MINUS) ||
                      (kind == etc_pkg::KIND_OPEN);
  assign seq_err    = have_r && prev_needs && !op_start;

  always_comb begin
    case (kind)
      etc_pkg::KIND_ERROR: code = etc_pkg::STATUS_SYNTAX;
      etc_pkg::KIND_OPEN:
        code = (depth_r >= DEPTH_W'(MAX_PAREN_DEPTH)) ? etc_pkg::STATUS_PAREN
                                                      : etc_pkg::STATUS_OK;
      etc_pkg::KIND_CLOSE:
        code = (depth_r == '0) ? etc_pkg::STATUS_PAREN : etc_pkg::STATUS_OK;
      etc_pkg::KIND_STAR, etc_pkg::KIND_SLASH, etc_pkg::KIND_CARET:
        code = first_r ? etc_pkg::STATUS_SYNTAX : etc_pkg::STATUS_OK;
      default: code = etc_pkg::STATUS_OK;
    endcase
  end

  always_comb begin
    if (!have_r) begin
      end_status = etc_pkg::STATUS_EMPTY;
    end else if (err_r != etc_pkg::STATUS_OK) begin
      end_status = err_r;
    end else if (prev_needs) begin
      end_status = etc_pkg::STATUS_SYNTAX;
    end else if (depth_r != '0) begin
      end_status = etc_pkg::STATUS_PAREN;
    end else begin
      end_status = etc_pkg::STATUS_OK;
    end
  end

  always_comb begin
    prev_nxt  = prev_r;
    have_nxt  = have_r;
    first_nxt = first_r;
    depth_nxt = depth_r;
    err_nxt   = err_r;
    res_new.kind   = kind;
    res_new.start  = head.tok.start;
    res_new.length = head.tok.length;
    res_new.last   = head.tok.last;
    res_new.status = etc_pkg::STATUS_OK;
    if (kind == etc_pkg::KIND_END) begin
      res_new.status = end_status;
      if (rd) begin
        prev_nxt  = etc_pkg::KIND_NUMBER;
        have_nxt  = 1'b0;
        first_nxt = 1'b1;
        depth_nxt = '0;
        err_nxt   = etc_pkg::STATUS_OK;
      end
    end else if (rd) begin
      prev_nxt  = kind;
      have_nxt  = 1'b1;
      first_nxt = 1'b0;
      if (err_r == etc_pkg::STATUS_OK) begin
        err_nxt = seq_err ? etc_pkg::STATUS_SYNTAX : code;
      end
      if ((kind == etc_pkg::KIND_OPEN) && (depth_r < DEPTH_W'(MAX_PAREN_DEPTH))) begin
        depth_nxt = depth_r + DEPTH_W'(1);
      end else if ((kind == etc_pkg::KIND_CLOSE) && (depth_r != '0)) begin
        depth_nxt = depth_r - DEPTH_W'(1);
      end
    end
  end

  assign empty  = (oq_cnt_r == 2'd0);
  assign do_pop = pop && !empty;
  assign res    = oq_r[oq_head_r];

  always_comb begin
    oq_head_nxt = do_pop ? !oq_head_r : oq_head_r;
    oq_cnt_nxt  = oq_cnt_r + 2'(rd) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      oq_r[oq_head_r ^ oq_cnt_r[0]] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= etc_pkg::KIND_NUMBER;
      have_r    <= 1'b0;
      first_r   <= 1'b1;
      depth_r   <= '0;
      err_r     <= etc_pkg::STATUS_OK;
      oq_head_r <= 1'b0;
      oq_cnt_r  <= 2'd0;
    end else begin
      prev_r    <= prev_nxt;
      have_r    <= have_nxt;
      first_r   <= first_nxt;
      depth_r   <= depth_nxt;
      err_r     <= err_nxt;
      oq_head_r <= oq_head_nxt;
      oq_cnt_r  <= oq_cnt_nxt;
    end
  end

endmodule

[hdl/expression_tokenizer_checker_core.sv]
// Top level of the expression tokenizer and checker.
// Instantiates etc_front, etc_tok_queue and etc_back; uses etc_pkg.
//
//   Channel  Handshake            Word
//   input    push / full          in_ch, in_end_of_text
//   result   empty / pop          out_token_kind, out_token_start, out_token_length,
//                                 out_check_status, out_last_of_run
//
// One character word is accepted per cycle while full is low. Each word yields
// zero, one or two tokens; the checker retires one token per cycle while the
// result queue has room, which keeps pace because every token after the first
// in a word is paid for by a character that produced none. Each token is written
// into the token queue and then into the result queue before it appears on the
// result ports, a second token of a word after the first. Reset is synchronous,
// active low. full rises when the token queue cannot take two more tokens; a
// stalled result side backs up through the result queue and token queue into full.
module expression_tokenizer_checker_core #(
  parameter longint unsigned MAX_TEXT_LENGTH = 65535,
  parameter int unsigned     MAX_PAREN_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_text,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [1:0]  out_check_status,
  output logic        out_last_of_run
);

  etc_pkg::tq_wr_t   tq_wr;
  etc_pkg::tq_head_t tq_head;
  etc_pkg::res_t     res;
  logic              tq_room;
  logic              tq_rd;

  // The front scans characters and emits raw tokens with positions.
  etc_front #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_ch          (in_ch),
    .in_end_of_text (in_end_of_text),
    .room           (tq_room),
    .full           (full),
    .wr             (tq_wr)
  );

  // The token queue decouples the two sides so each may stall on its own.
  etc_tok_queue u_tok_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tq_wr),
    .rd    (tq_rd),
    .room  (tq_room),
    .head  (tq_head)
  );

  // The back checks token order and parenthesis depth and holds results.
  etc_back #(
    .MAX_PAREN_DEPTH(MAX_PAREN_DEPTH)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (tq_head),
    .rd    (tq_rd),
    .pop   (pop),
    .empty (empty),
    .res   (res)
  );

  assign out_token_kind   = res.kind;
  assign out_token_start  = res.start;
  assign out_token_length = res.length;
  assign out_check_status = res.status;
  assign out_last_of_run  = res.last;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for expression_tokenizer_checker_core: queue-driven
// character driver, token monitor and an in-bench lexer/checker predictor.
// Depends on etc_pkg and the hdl/ sources.
module tb;

  // Limits of the default build, mirrored by the predictor.
  localparam int POS_LIMIT   = 65535;
  localparam int DEPTH_LIMIT = 255;

  // Cycles waited after the last expected token.
  localparam int TAIL_CYCLES = 12;
  // Length of the one long receiver hold-off, and when it starts.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_DELAY  = 60;

  typedef enum logic [3:0] {
    SCAN_IDLE  = 4'b0001,
    SCAN_INT   = 4'b0010,
    SCAN_FRAC  = 4'b0100,
    SCAN_IDENT = 4'b1000
  } scan_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One input word as it waits to be driven.
  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
  } char_word_t;

  logic        clk;
  logic        rst_n;
  logic        push = 1'b0;
  logic [7:0]  in_ch = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [1:0]  out_check_status;
  logic        out_last_of_run;

  expression_tokenizer_checker_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .in_ch            (in_ch),
    .in_end_of_text   (in_end_of_text),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_check_status (out_check_status),
    .out_last_of_run  (out_last_of_run)
  );

  // Words waiting for the driver, and tokens waiting for the monitor.
  char_word_t     word_q[$];
  etc_pkg::res_t  token_q[$];
  logic [7:0]     text_q[$];
  char_word_t     next_word;

  idle_mode_t  idle_mode = IDLE_NONE;
  logic        hold_rx;

  int unsigned n_sent = 0;
  int unsigned n_acc = 0;
  int unsigned n_expr = 0;
  int unsigned n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned n_status[4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Lexer and checker predictor. It keeps its own copy of the scan state and
  // turns every accepted word into the tokens the core has to produce.
  // ---------------------------------------------------------------------------
  scan_t             lx_mode;
  logic [15:0]       lx_pos;
  logic [15:0]       lx_tok_start;
  etc_pkg::kind_t    lx_prev;
  logic              lx_have_prev;
  logic              lx_first;
  logic [7:0]        lx_depth;
  etc_pkg::status_t  lx_err;
  // The newest token of the current word is held back until we know whether
  // it is the word's final one, which carries the last flag.
  etc_pkg::res_t     staged;
  logic              staged_valid = 1'b0;

  task automatic lexer_reset();
    lx_mode      = SCAN_IDLE;
    lx_pos       = 16'd0;
    lx_tok_start = 16'd0;
    lx_prev      = etc_pkg::KIND_NUMBER;
    lx_have_prev = 1'b0;
    lx_first     = 1'b1;
    lx_depth     = 8'd0;
    lx_err       = etc_pkg::STATUS_OK;
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Operators and an open parenthesis must be followed by an operand.
  function automatic logic needs_operand(input etc_pkg::kind_t k);
    return k >= etc_pkg::KIND_PLUS && k <= etc_pkg::KIND_OPEN;
  endfunction

  function automatic logic starts_operand(input etc_pkg::kind_t k);
    return k == etc_pkg::KIND_NUMBER || k == etc_pkg::KIND_IDENT ||
           k == etc_pkg::KIND_PLUS || k == etc_pkg::KIND_MINUS ||
           k == etc_pkg::KIND_OPEN;
  endfunction

  task automatic note_error(input etc_pkg::status_t code);
    if (lx_err == etc_pkg::STATUS_OK) lx_err = code;
  endtask

  task automatic stage_token(input etc_pkg::kind_t k, input logic [15:0] s,
                             input logic [15:0] l, input etc_pkg::status_t st);
    if (staged_valid) token_q = {token_q, staged};
    staged.kind   = k;
    staged.start  = s;
    staged.length = l;
    staged.status = st;
    staged.last   = 1'b0;
    staged_valid  = 1'b1;
  endtask

  task automatic close_word();
    if (staged_valid) begin
      staged.last = 1'b1;
      token_q = {token_q, staged};
      staged_valid = 1'b0;
    end
  endtask

  // Applies the pairwise and depth rules to one token, then queues it.
  task automatic record_token(input etc_pkg::kind_t k, input logic [15:0] s,
                              input logic [15:0] l);
    if (lx_have_prev && needs_operand(lx_prev) && !starts_operand(k)) begin
      note_error(etc_pkg::STATUS_SYNTAX);
    end
    if (k == etc_pkg::KIND_ERROR) begin
      note_error(etc_pkg::STATUS_SYNTAX);
    end else if (k == etc_pkg::KIND_OPEN) begin
      // Overflow is a parenthesis error and the depth stays where it is.
      if (lx_depth >= DEPTH_LIMIT) note_error(etc_pkg::STATUS_PAREN);
      else lx_depth = lx_depth + 8'd1;
    end else if (k == etc_pkg::KIND_CLOSE) begin
      if (lx_depth == 8'd0) note_error(etc_pkg::STATUS_PAREN);
      else lx_depth = lx_depth - 8'd1;
    end else if ((k == etc_pkg::KIND_STAR || k == etc_pkg::KIND_SLASH ||
                  k == etc_pkg::KIND_CARET) && lx_first) begin
      note_error(etc_pkg::STATUS_SYNTAX);
    end
    lx_prev      = k;
    lx_have_prev = 1'b1;
    lx_first     = 1'b0;
    stage_token(k, s, l, etc_pkg::STATUS_OK);
  endtask

  task automatic flush_run();
    if (lx_mode == SCAN_INT || lx_mode == SCAN_FRAC)
      record_token(etc_pkg::KIND_NUMBER, lx_tok_start, lx_pos - lx_tok_start);
    else if (lx_mode == SCAN_IDENT)
      record_token(etc_pkg::KIND_IDENT, lx_tok_start, lx_pos - lx_tok_start);
    lx_mode = SCAN_IDLE;
  endtask

  // Positions saturate at the limit.
  task automatic advance();
    if (lx_pos < POS_LIMIT) lx_pos = lx_pos + 16'd1;
  endtask

  task automatic predict_word(input logic [7:0] ch, input logic eot);
    etc_pkg::status_t st;
    etc_pkg::kind_t   k;
    if (eot) begin
      flush_run();
      if (!lx_have_prev) begin
        st = etc_pkg::STATUS_EMPTY;
      end else begin
        if (needs_operand(lx_prev)) note_error(etc_pkg::STATUS_SYNTAX);
        if (lx_depth != 8'd0) note_error(etc_pkg::STATUS_PAREN);
        st = lx_err;
      end
      stage_token(etc_pkg::KIND_END, lx_pos, 16'd0, st);
      close_word();
      lexer_reset();
    end else if ((lx_mode == SCAN_INT && (is_digit(ch) || ch == etc_pkg::CH_DOT)) ||
                 (lx_mode == SCAN_FRAC && is_digit(ch)) ||
                 (lx_mode == SCAN_IDENT && is_letter(ch))) begin
      // The run goes on; a dot in the integer part starts the fraction.
      if (lx_mode == SCAN_INT && ch == etc_pkg::CH_DOT) lx_mode = SCAN_FRAC;
      advance();
    end else begin
      flush_run();
      if (is_space(ch)) begin
        // Whitespace only moves the position.
      end else if (is_digit(ch)) begin
        lx_mode      = SCAN_INT;
        lx_tok_start = lx_pos;
      end else if (is_letter(ch)) begin
        lx_mode      = SCAN_IDENT;
        lx_tok_start = lx_pos;
      end else begin
        // A second dot lands here too and becomes an error token.
        case (ch)
          etc_pkg::CH_PLUS:  k = etc_pkg::KIND_PLUS;
          etc_pkg::CH_MINUS: k = etc_pkg::KIND_MINUS;
          etc_pkg::CH_STAR:  k = etc_pkg::KIND_STAR;
          etc_pkg::CH_SLASH: k = etc_pkg::KIND_SLASH;
          etc_pkg::CH_CARET: k = etc_pkg::KIND_CARET;
          etc_pkg::CH_OPEN:  k = etc_pkg::KIND_OPEN;
          etc_pkg::CH_CLOSE: k = etc_pkg::KIND_CLOSE;
          default:           k = etc_pkg::KIND_ERROR;
        endcase
        record_token(k, lx_pos, 16'd1);
      end
      advance();
      close_word();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and run limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The slowest correct run stays well below a million nanoseconds.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver. A word is taken when push is high and full is low at the edge; the
  // word is then handed to the predictor and the next one, if any, is offered.
  // A word on offer is held until it is taken, so push never drops early.
  // ---------------------------------------------------------------------------
  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 50;
      IDLE_BOTH:   return $urandom_range(0, 99) < 9;
      default:     return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      push           <= 1'b0;
      in_ch          <= 8'h00;
      in_end_of_text <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_word(in_ch, in_end_of_text);
        n_acc = n_acc + 1;
      end
      if (!push || !full) begin
        if (word_q.size() != 0 && !sender_idles()) begin
          next_word = word_q.pop_front();
          push           <= 1'b1;
          in_ch          <= next_word.ch;
          in_end_of_text <= next_word.eot;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every token taken off the result side is compared with the oldest
  // prediction; pop is re-decided every cycle.
  // ---------------------------------------------------------------------------
  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 50;
      IDLE_BOTH:     return $urandom_range(0, 99) < 9;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic check_token();
    etc_pkg::res_t want;
    etc_pkg::res_t got;
    got.kind   = etc_pkg::kind_t'(out_token_kind);
    got.start  = out_token_start;
    got.length = out_token_length;
    got.status = etc_pkg::status_t'(out_check_status);
    got.last   = out_last_of_run;
    if (token_q.size() == 0) begin
      n_fail = n_fail + 1;
      $display("%0t: unexpected token: kind %0d start %0d length %0d status %0d last %0d",
               $time, got.kind, got.start, got.length, got.status, got.last);
    end else begin
      want = token_q.pop_front();
      n_checked = n_checked + 1;
      if (want.kind == etc_pkg::KIND_END) n_status[want.status] = n_status[want.status] + 1;
      if (got !== want) begin
        n_fail = n_fail + 1;
        $display("%0t: token %0d expected kind %0d start %0d len %0d status %0d last %0d",
                 $time, n_checked, want.kind, want.start, want.length, want.status,
                 want.last);
        $display("%0t: token %0d actual   kind %0d start %0d len %0d status %0d last %0d",
                 $time, n_checked, got.kind, got.start, got.length, got.status,
                 got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_token();
      pop <= !(hold_rx || receiver_stalls());
    end
  end

  // One long hold-off on the result side early in the first phase. The sender
  // keeps offering words meanwhile, so the core's queues fill and full rises.
  initial begin
    hold_rx = 1'b0;
    @(posedge rst_n);
    repeat (HOLD_DELAY) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic put_word(input logic [7:0] ch, input logic eot);
    char_word_t w;
    w.ch  = ch;
    w.eot = eot;
    word_q = {word_q, w};
    n_sent = n_sent + 1;
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
  endtask

  // The character that rides along with the end marker is meant to be ignored.
  task automatic put_end();
    put_word(8'($urandom_range(0, 255)), 1'b1);
    n_expr = n_expr + 1;
  endtask

  // Appends one character to the text being built.
  task automatic text_add(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  function automatic logic [7:0] pick_space();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return etc_pkg::CH_PLUS;
      1:       return etc_pkg::CH_MINUS;
      2:       return etc_pkg::CH_STAR;
      3:       return etc_pkg::CH_SLASH;
      default: return etc_pkg::CH_CARET;
    endcase
  endfunction

  // Half the time any byte at all, otherwise a character that the scanner
  // treats specially.
  function automatic logic [7:0] pick_noise();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return etc_pkg::CH_DOT;
      1:       return etc_pkg::CH_OPEN;
      2:       return etc_pkg::CH_CLOSE;
      3:       return pick_operator();
      4:       return "0" + 8'($urandom_range(0, 9));
      default: return pick_space();
    endcase
  endfunction

  task automatic text_gap();
    if ($urandom_range(0, 99) < 30) text_add(pick_space());
  endtask

  task automatic gen_number();
    repeat ($urandom_range(1, 4)) text_add("0" + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 0) begin
      text_add(etc_pkg::CH_DOT);
      repeat ($urandom_range(0, 3)) text_add("0" + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic gen_ident();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 1) == 0) text_add("a" + 8'($urandom_range(0, 25)));
      else text_add("A" + 8'($urandom_range(0, 25)));
    end
  endtask

  // A well-formed expression: operands joined by binary operators, with an
  // occasional unary sign and balanced parentheses up to four deep.
  task automatic gen_expression();
    int n_operands;
    int opens;
    int i;
    n_operands = $urandom_range(1, 6);
    opens = 0;
    for (i = 0; i < n_operands; i++) begin
      text_gap();
      if ($urandom_range(0, 9) == 0) begin
        text_add(($urandom_range(0, 1) == 0) ? etc_pkg::CH_MINUS : etc_pkg::CH_PLUS);
        text_gap();
      end
      while (opens < 4 && $urandom_range(0, 4) == 0) begin
        text_add(etc_pkg::CH_OPEN);
        opens++;
        text_gap();
      end
      if ($urandom_range(0, 1) == 0) gen_number();
      else gen_ident();
      text_gap();
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        text_add(etc_pkg::CH_CLOSE);
        opens--;
        text_gap();
      end
      if (i < n_operands - 1) text_add(pick_operator());
    end
    while (opens > 0) begin
      text_add(etc_pkg::CH_CLOSE);
      opens--;
    end
  endtask

  // Breaks a text by overwriting, inserting or dropping one character.
  task automatic corrupt_text();
    int unsigned at;
    logic [7:0]  c;
    c = pick_noise();
    if (text_q.size() == 0) begin
      text_add(c);
    end else begin
      at = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 2))
        0:       text_q[at] = c;
        1:       text_q.insert(at, c);
        default: text_q.delete(at);
      endcase
    end
  endtask

  // Mostly well-formed expressions, then broken ones, raw noise and empty text.
  task automatic add_random(input int unsigned n_words);
    int unsigned first_count;
    int unsigned r;
    int          i;
    first_count = n_sent;
    while (n_sent - first_count < n_words) begin
      text_q.delete();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        gen_expression();
      end else if (r < 82) begin
        gen_expression();
        repeat ($urandom_range(1, 2)) corrupt_text();
      end else if (r < 95) begin
        repeat ($urandom_range(1, 12)) text_add(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) text_gap();
      for (i = 0; i < text_q.size(); i++) put_word(text_q[i], 1'b0);
      put_end();
    end
  endtask

  task automatic wait_drained();
    while (n_acc != n_sent || token_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    lexer_reset();

    // Directed: empty text; every operator with a fractional number, names and
    // trailing whitespace; a leading star, a second dot and an unmatched close;
    // the two extreme byte values as error tokens followed by an unclosed open.
    put_end();
    put_text("1.5+ab*(c-d)/2^x\t");
    put_end();
    put_text("*1.2.3)");
    put_end();
    put_word(8'hFF, 1'b0);
    put_word(8'h00, 1'b0);
    put_word(etc_pkg::CH_OPEN, 1'b0);
    put_end();

    add_random(190);

    // Depth overflow: one open more than the counter holds.
    repeat (DEPTH_LIMIT + 1) put_word(etc_pkg::CH_OPEN, 1'b0);
    put_text("x");
    repeat (DEPTH_LIMIT) put_word(etc_pkg::CH_CLOSE, 1'b0);
    put_end();

    wait_drained();

    idle_mode = IDLE_SENDER;
    add_random(170);
    wait_drained();

    idle_mode = IDLE_RECEIVER;
    add_random(170);
    wait_drained();

    idle_mode = IDLE_BOTH;
    add_random(170);
    wait_drained();

    $display("Covered %0d expressions in %0d words over four idling phases.", n_expr, n_acc);
    $display("Checked %0d tokens; end statuses ok %0d, empty %0d, syntax %0d, paren %0d.",
             n_checked, n_status[etc_pkg::STATUS_OK], n_status[etc_pkg::STATUS_EMPTY],
             n_status[etc_pkg::STATUS_SYNTAX], n_status[etc_pkg::STATUS_PAREN]);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/etc_pkg.sv
hdl/etc_front.sv
hdl/etc_tok_queue.sv
hdl/etc_back.sv
hdl/expression_tokenizer_checker_core.sv
tb/tb.sv
